### sv/stai_pkg.sv
// ============================================================================
// stai_pkg
// Types, constants, microcode table and arctangent table shared by the
// stick-to-attitude-target integrator.
// ============================================================================
package stai_pkg;

  localparam int ANGLE_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fixed-point angle constants, LSB 2^-20 rad
  localparam logic signed [23:0] ANG_PI      = 24'sd3294199;
  localparam logic signed [23:0] ANG_HALF_PI = 24'sd1647099;
  // CORDIC start vector, 0.607252935 on a 2^-30 scale
  localparam logic signed [31:0] CORDIC_K30  = 32'sd652032874;

  localparam int PINC_W = 23;  // width of the pitch increment after the shift

  // Register reset values
  localparam logic [11:0] SERVO_CENTER_RST = 12'd1500;
  localparam logic [9:0]  DEAD_BAND_RST    = 10'd50;
  localparam logic [15:0] STICK_GAIN_RST   = 16'd53687;
  localparam logic [21:0] ANGLE_LIMIT_RST  = 22'd1098066;

  typedef enum logic [1:0] {
    REG_SERVO_CENTER = 2'd0,
    REG_DEAD_BAND    = 2'd1,
    REG_STICK_GAIN   = 2'd2,
    REG_ANGLE_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_NAV  = 2'd0,
    REQ_TAKE = 2'd1,
    REQ_REL  = 2'd2
  } req_e;

  typedef struct packed {
    logic [11:0] servo_center;
    logic [9:0]  dead_band;
    logic [15:0] stick_gain;
    logic [21:0] angle_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [22:0] roll_angle;
    logic signed [22:0] pitch_angle;
    logic [11:0]        elevator_raw;
    logic [11:0]        rudder_raw;
    logic [11:0]        aileron_raw;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               loop_last;
    logic signed [23:0] pitch_target;
    logic signed [23:0] roll_target;
    logic               controller_enabled;
    logic               controller_reset;
  } dp_stat_t;

  typedef struct packed {
    logic idle;
    logic out_load;
  } seq_stat_t;

  // Microcode fields
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR_PULSE,
    OP_CINIT,
    OP_CITER,
    OP_ROUND,
    OP_UPDATE,
    OP_TAKE,
    OP_RELEASE
  } dp_op_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ELEV,
    MUL_RUD,
    MUL_AIL,
    MUL_COS_E,
    MUL_SIN_R
  } mul_src_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_E,
    DST_R,
    DST_A,
    DST_ACC_NEG,
    DST_ACC_SUB
  } mul_dst_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,
    J_DISPATCH,
    J_LOOP,
    J_GOTO,
    J_OUT_WAIT
  } jmp_e;

  localparam int PC_W = 4;

  // Step addresses
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_DISP  = 4'd1;
  localparam logic [PC_W-1:0] S_CINIT = 4'd2;
  localparam logic [PC_W-1:0] S_C1    = 4'd3;
  localparam logic [PC_W-1:0] S_C2    = 4'd4;
  localparam logic [PC_W-1:0] S_C3    = 4'd5;
  localparam logic [PC_W-1:0] S_CLOOP = 4'd6;
  localparam logic [PC_W-1:0] S_ROUND = 4'd7;
  localparam logic [PC_W-1:0] S_MCOS  = 4'd8;
  localparam logic [PC_W-1:0] S_MSIN  = 4'd9;
  localparam logic [PC_W-1:0] S_ACC   = 4'd10;
  localparam logic [PC_W-1:0] S_UPD   = 4'd11;
  localparam logic [PC_W-1:0] S_OUT   = 4'd12;
  localparam logic [PC_W-1:0] S_TAKE  = 4'd13;
  localparam logic [PC_W-1:0] S_REL   = 4'd14;

  typedef struct packed {
    dp_op_e          op;
    mul_src_e        mul;
    mul_dst_e        dst;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, mul: MUL_NONE, dst: DST_NONE, jmp: J_NEXT, target: S_IDLE};
    case (pc)
      S_IDLE:  w.jmp = J_WAIT_IN;
      S_DISP:  begin w.op = OP_CLR_PULSE; w.jmp = J_DISPATCH; end
      S_CINIT: begin w.op = OP_CINIT; w.mul = MUL_ELEV; end
      S_C1:    begin w.op = OP_CITER; w.mul = MUL_RUD; w.dst = DST_E; end
      S_C2:    begin w.op = OP_CITER; w.mul = MUL_AIL; w.dst = DST_R; end
      S_C3:    begin w.op = OP_CITER; w.dst = DST_A; end
      S_CLOOP: begin w.op = OP_CITER; w.jmp = J_LOOP; end
      S_ROUND: w.op = OP_ROUND;
      S_MCOS:  w.mul = MUL_COS_E;
      S_MSIN:  begin w.mul = MUL_SIN_R; w.dst = DST_ACC_NEG; end
      S_ACC:   w.dst = DST_ACC_SUB;
      S_UPD:   w.op = OP_UPDATE;
      S_OUT:   begin w.jmp = J_OUT_WAIT; w.target = S_IDLE; end
      S_TAKE:  begin w.op = OP_TAKE; w.jmp = J_GOTO; w.target = S_OUT; end
      S_REL:   begin w.op = OP_RELEASE; w.jmp = J_GOTO; w.target = S_OUT; end
      default: begin w.jmp = J_GOTO; w.target = S_IDLE; end
    endcase
    return w;
  endfunction

  // atan(2^-i) in 2^-20 rad, rounded to nearest
  function automatic logic [19:0] atan_lut(input logic [4:0] idx);
    logic [19:0] v;
    case (idx)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/stai_sequencer.sv
// ============================================================================
// stai_sequencer
// Step counter and microcode table; picks the next step from the jump field.
// ============================================================================
module stai_sequencer import stai_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic       out_free_i,
  input  dp_stat_t   dp_stat_i,
  output ctrl_word_t ctrl_o,
  output seq_stat_t  stat_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      ctrl;

  assign ctrl = ucode_rom(pc_q);

  always_comb begin
    pc_d = pc_q + 1'b1;
    case (ctrl.jmp)
      J_NEXT:     pc_d = pc_q + 1'b1;
      J_WAIT_IN:  pc_d = in_fire_i ? pc_q + 1'b1 : pc_q;
      J_DISPATCH: begin
        case (dp_stat_i.req_type)
          REQ_NAV:  pc_d = S_CINIT;
          REQ_TAKE: pc_d = S_TAKE;
          REQ_REL:  pc_d = S_REL;
          default:  pc_d = S_OUT;
        endcase
      end
      J_LOOP:     pc_d = dp_stat_i.loop_last ? pc_q + 1'b1 : pc_q;
      J_GOTO:     pc_d = ctrl.target;
      J_OUT_WAIT: pc_d = out_free_i ? ctrl.target : pc_q;
      default:    pc_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o          = ctrl;
  assign stat_o.idle     = (pc_q == S_IDLE);
  assign stat_o.out_load = (ctrl.jmp == J_OUT_WAIT) && out_free_i;

endmodule

### sv/stai_datapath.sv
// ============================================================================
// stai_datapath
// Input latch, shared multiplier, shift-add CORDIC unit and goal registers,
// all driven by the microcode word.
// ============================================================================
module stai_datapath import stai_pkg::*; #(
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  in_item_t   in_item_i,
  input  cfg_t       cfg_i,
  input  ctrl_word_t ctrl_i,
  output dp_stat_t   stat_o
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int SW = ((ANGLE_WIDTH > PINC_W) ? ANGLE_WIDTH : PINC_W) + 2;

  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [17:0] r;
    logic signed [15:0] q;
    t = 33'(v) + 33'sd16384;
    r = 18'(t >>> 15);
    if (r > 18'sd32767) begin
      q = 16'sh7fff;
    end else if (r < -18'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  // Latched input item
  in_item_t item_q;

  // Multiplier
  logic [11:0]        raw_sel;
  logic signed [12:0] off, db_s, dbo;
  logic signed [15:0] ma;
  logic signed [20:0] mb;
  logic signed [36:0] prod, p_q;

  // Stick increments, rounded sin/cos, pitch accumulator
  logic signed [20:0] e_q, r_q, a_q;
  logic signed [15:0] c_q, s_q;
  logic signed [37:0] acc_q;

  // CORDIC
  logic signed [31:0] x_q, y_q, xs, ys;
  logic signed [23:0] z_q, z_init, roll_ext, at;
  logic               neg_q, fold;
  logic [IW-1:0]      i_q;

  // Goals
  logic signed [ANGLE_WIDTH-1:0] pitch_goal_q, roll_goal_q;
  logic signed [ANGLE_WIDTH-1:0] pitch_goal_d, roll_goal_d;
  logic                          engaged_q, engaged_d, pulse_q, pulse_d;
  logic signed [PINC_W-1:0]      pinc;
  logic signed [SW-1:0]          lim, psum, rsum, psat, rsat;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      item_q <= in_item_i;
    end
  end

  // Center, deadband and operand select
  always_comb begin
    case (ctrl_i.mul)
      MUL_RUD: raw_sel = item_q.rudder_raw;
      MUL_AIL: raw_sel = item_q.aileron_raw;
      default: raw_sel = item_q.elevator_raw;
    endcase
    off  = $signed({1'b0, raw_sel}) - $signed({1'b0, cfg_i.servo_center});
    db_s = $signed({3'b000, cfg_i.dead_band});
    dbo  = ((off > -db_s) && (off < db_s)) ? 13'sd0 : off;
    case (ctrl_i.mul)
      MUL_ELEV, MUL_RUD, MUL_AIL: begin
        ma = 16'(dbo);
        mb = $signed({5'b00000, cfg_i.stick_gain});
      end
      MUL_COS_E: begin
        ma = c_q;
        mb = e_q;
      end
      MUL_SIN_R: begin
        ma = s_q;
        mb = r_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul != MUL_NONE) begin
      p_q <= prod;
    end
    case (ctrl_i.dst)
      DST_E:       e_q <= $signed(p_q[28:8]);
      DST_R:       r_q <= $signed(p_q[28:8]);
      DST_A:       a_q <= $signed(p_q[28:8]);
      DST_ACC_NEG: acc_q <= -38'(p_q);
      DST_ACC_SUB: acc_q <= acc_q - 38'(p_q);
      default: ;
    endcase
  end

  // Fold the roll into plus or minus a right angle
  always_comb begin
    roll_ext = 24'(item_q.roll_angle);
    fold     = 1'b1;
    if (roll_ext > ANG_HALF_PI) begin
      z_init = roll_ext - ANG_PI;
    end else if (roll_ext < -ANG_HALF_PI) begin
      z_init = roll_ext + ANG_PI;
    end else begin
      z_init = roll_ext;
      fold   = 1'b0;
    end
  end

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed({4'b0000, atan_lut(5'(i_q))});

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_CINIT: begin
        x_q   <= CORDIC_K30;
        y_q   <= '0;
        z_q   <= z_init;
        neg_q <= fold;
        i_q   <= '0;
      end
      OP_CITER: begin
        if (!z_q[23]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        i_q <= i_q + 1'b1;
      end
      OP_ROUND: begin
        c_q <= to_q15(neg_q ? -x_q : x_q);
        s_q <= to_q15(neg_q ? -y_q : y_q);
      end
      default: ;
    endcase
  end

  // Integrate and saturate
  always_comb begin
    pinc = acc_q[37:15];
    lim  = $signed(SW'(cfg_i.angle_limit));
    psum = SW'(pitch_goal_q) + SW'(pinc);
    rsum = SW'(roll_goal_q) + SW'(a_q);
    if (psum > lim) begin
      psat = lim;
    end else if (psum < -lim) begin
      psat = -lim;
    end else begin
      psat = psum;
    end
    if (rsum > lim) begin
      rsat = lim;
    end else if (rsum < -lim) begin
      rsat = -lim;
    end else begin
      rsat = rsum;
    end

    pitch_goal_d = pitch_goal_q;
    roll_goal_d  = roll_goal_q;
    engaged_d    = engaged_q;
    pulse_d      = pulse_q;
    case (ctrl_i.op)
      OP_CLR_PULSE: pulse_d = 1'b0;
      OP_UPDATE: begin
        pitch_goal_d = psat[ANGLE_WIDTH-1:0];
        roll_goal_d  = rsat[ANGLE_WIDTH-1:0];
      end
      OP_TAKE: begin
        pitch_goal_d = ANGLE_WIDTH'(item_q.pitch_angle);
        roll_goal_d  = ANGLE_WIDTH'(item_q.roll_angle);
        engaged_d    = 1'b1;
        pulse_d      = 1'b1;
      end
      OP_RELEASE: engaged_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_goal_q <= '0;
      roll_goal_q  <= '0;
      engaged_q    <= 1'b0;
      pulse_q      <= 1'b0;
    end else begin
      pitch_goal_q <= pitch_goal_d;
      roll_goal_q  <= roll_goal_d;
      engaged_q    <= engaged_d;
      pulse_q      <= pulse_d;
    end
  end

  assign stat_o.req_type           = item_q.req_type;
  assign stat_o.loop_last          = (i_q == IW'(CORDIC_STEPS - 1));
  assign stat_o.pitch_target       = 24'(pitch_goal_q);
  assign stat_o.roll_target        = 24'(roll_goal_q);
  assign stat_o.controller_enabled = engaged_q;
  assign stat_o.controller_reset   = pulse_q;

endmodule

### sv/stick_to_attitude_target_integrator.sv
// ============================================================================
// stick_to_attitude_target_integrator
// Turns radio stick readings into saturated pitch and roll attitude targets
// under control of a small microcode program.
// ============================================================================
//
//  Channel  Dir  Handshake               Payload
//  -------  ---  ----------------------  ------------------------------------
//  s_*      in   s_tvalid / s_tready     tuser: req_type; tdata: roll, pitch,
//                                        elevator, rudder, aileron
//  m_*      out  m_tvalid / m_tready     tdata: pitch_target, roll_target,
//                                        controller_enabled, controller_reset
//  apb      in   psel/penable, pready=1  four config registers at 4*index
//
//  A navigate beat runs the CORDIC loop at one shift-add iteration per cycle.
//  Takeover, release and an unused code go straight to the final step. The
//  input is taken again in the cycle after the result is loaded, so no new
//  beat is accepted while one is in flight. Reset clears goals, engaged flag,
//  step counter and output valid; a stalled output holds the final step.
//
module stick_to_attitude_target_integrator import stai_pkg::*; #(
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // roll_angle, pitch_angle, elevator_raw,
                                 // rudder_raw, aileron_raw, zero fill
  input  logic [1:0]  s_tuser,   // req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pitch_target, roll_target,
                                 // controller_enabled, controller_reset, zero fill
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  in_item_t   in_item;
  ctrl_word_t ctrl;
  dp_stat_t   dp_stat;
  seq_stat_t  seq_stat;
  logic       s_fire, out_free, cfg_wr;
  reg_idx_e   cfg_idx;

  logic       m_valid_q, m_valid_d;
  dp_stat_t   m_data_q;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes decode on the word index only
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_center <= SERVO_CENTER_RST;
      cfg_q.dead_band    <= DEAD_BAND_RST;
      cfg_q.stick_gain   <= STICK_GAIN_RST;
      cfg_q.angle_limit  <= ANGLE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SERVO_CENTER: cfg_q.servo_center <= pwdata[11:0];
        REG_DEAD_BAND:    cfg_q.dead_band    <= pwdata[9:0];
        REG_STICK_GAIN:   cfg_q.stick_gain   <= pwdata[15:0];
        REG_ANGLE_LIMIT:  cfg_q.angle_limit  <= pwdata[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SERVO_CENTER: prdata = {20'd0, cfg_q.servo_center};
      REG_DEAD_BAND:    prdata = {22'd0, cfg_q.dead_band};
      REG_STICK_GAIN:   prdata = {16'd0, cfg_q.stick_gain};
      REG_ANGLE_LIMIT:  prdata = {10'd0, cfg_q.angle_limit};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input beat unpack; take a beat only while the program sits at its idle step
  // ---------------------------------------------------------------------------
  assign s_tready = seq_stat.idle;
  assign s_fire   = s_tvalid && s_tready;

  assign in_item.req_type     = s_tuser;
  assign in_item.roll_angle   = $signed(s_tdata[22:0]);
  assign in_item.pitch_angle  = $signed(s_tdata[45:23]);
  assign in_item.elevator_raw = s_tdata[57:46];
  assign in_item.rudder_raw   = s_tdata[69:58];
  assign in_item.aileron_raw  = s_tdata[81:70];

  // Output register is free when empty or drained this cycle
  assign out_free = !m_valid_q || m_tready;

  stai_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (s_fire),
    .out_free_i (out_free),
    .dp_stat_i  (dp_stat),
    .ctrl_o     (ctrl),
    .stat_o     (seq_stat)
  );

  stai_datapath #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (s_fire),
    .in_item_i (in_item),
    .cfg_i     (cfg_q),
    .ctrl_i    (ctrl),
    .stat_o    (dp_stat)
  );

  // ---------------------------------------------------------------------------
  // Output register: load at the final step, hold while stalled, drop on take
  // ---------------------------------------------------------------------------
  always_comb begin
    m_valid_d = m_valid_q;
    if (seq_stat.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_stat.out_load) begin
      m_data_q <= dp_stat;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {6'd0, m_data_q.controller_reset, m_data_q.controller_enabled,
                     m_data_q.roll_target, m_data_q.pitch_target};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A takeover result always reports the controller as engaged
  a_pulse_engaged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q.controller_reset |-> m_data_q.controller_enabled)
    else $error("controller reset reported while disengaged");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_stat.out_load |-> (!m_valid_q || m_tready))
    else $error("output register overwritten while stalled");

  // Once a beat is taken the program leaves its idle step
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_tready)
    else $error("input ready right after an accepted beat");

endmodule
